[sv/cif_pkg.sv]
package cif_pkg;

    localparam int PIXEL_BITS = 8;
    localparam int ROW_W      = 11;
    localparam int MAX_HEIGHT = 1024;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int SIZE_W     = 11;
    localparam int COEF_W     = 8;
    localparam int RESULT_W   = 16;

    // one signed weight times one unsigned pixel
    localparam int PROD_W = COEF_W + PIXEL_BITS + 1;
    // nine products
    localparam int SUM_W  = PROD_W + 4;
    localparam int MAG_W  = SUM_W - 1;

    // |x| / 9 == (|x| * DIV9_RECIP) >> DIV9_SHIFT, exact for |x| < 2**21
    localparam int              DIV9_SHIFT = 22;
    localparam logic [18:0]     DIV9_RECIP = 19'd466034;
    localparam int              DIVP_W     = MAG_W + 19;

    localparam logic [SIZE_W-1:0]     SIZE_RESET   = 11'd640;
    localparam logic [CFG_DATA_W-1:0] COEF_ALL_NEG = 24'hFFFFFF;
    localparam logic [CFG_DATA_W-1:0] COEF_CENTER8 = 24'hFF08FF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_COEF_TOP     = 3'd2,
        REG_COEF_MIDDLE  = 3'd3,
        REG_COEF_BOTTOM  = 3'd4
    } cif_reg_t;

    // upper row and lower row pixel held for one column
    typedef struct packed {
        logic [PIXEL_BITS-1:0] upper;
        logic [PIXEL_BITS-1:0] lower;
    } cif_pair_t;

    typedef struct packed {
        logic have;
        logic skip_left;
        logic skip_right;
        logic skip_top;
        logic skip_bottom;
        logic row_last;
        logic frame_last;
    } cif_ctl_t;

endpackage

[sv/cif_if.sv]
interface cif_pixel_if;
    logic                            valid;
    logic                            ready;
    logic                            op;
    logic [cif_pkg::PIXEL_BITS-1:0]  pixel;

    modport source (output valid, output op, output pixel, input ready);
    modport sink   (input valid, input op, input pixel, output ready);
endinterface

interface cif_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [cif_pkg::RESULT_W-1:0] filtered;
    logic                                row_last;
    logic                                frame_last;

    modport source (output valid, output filtered, output row_last, output frame_last,
                    input ready);
    modport sink   (input valid, input filtered, input row_last, input frame_last,
                    output ready);
endinterface

[sv/cif_line_store.sv]
module cif_line_store #(
    parameter int DEPTH = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr,
    input  logic                         wr_en,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  cif_pkg::cif_pair_t           wr_data,
    output cif_pkg::cif_pair_t           rd_data
);

    localparam int FW = $clog2(DEPTH + 1);

    cif_pkg::cif_pair_t mem [DEPTH];
    cif_pkg::cif_pair_t mem_q_reg;
    cif_pkg::cif_pair_t fwd_data_reg;
    logic               fwd_reg;
    logic               filled_reg;
    logic [FW-1:0]      fill_reg;

    // columns are always written as a prefix from zero, so a count marks what is valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            fwd_reg    <= 1'b0;
            filled_reg <= 1'b0;
        end
        else
        begin
            if (wr_en && (FW'(wr_addr) == fill_reg) && (fill_reg != FW'(DEPTH)))
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (rd_en)
            begin
                fwd_reg    <= wr_en && (wr_addr == rd_addr);
                filled_reg <= FW'(rd_addr) < fill_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mem_q_reg    <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_comb
    begin
        if (fwd_reg)
        begin
            rd_data = fwd_data_reg;
        end
        else if (filled_reg)
        begin
            rd_data = mem_q_reg;
        end
        else
        begin
            rd_data = '0;
        end
    end

endmodule

[sv/conv3x3_image_filter.sv]
// Path: the item completing a neighborhood (one row plus one pixel after its own pixel)
// enters stage 1 at accept, then the product, sum, reciprocal and output registers.
// Throughput: one item per cycle unless results.ready stalls; the line store is read at
// accept and written as the item leaves stage 1; a back-to-back column takes a bypass.
// Reset: sizes 640x640, Laplacian weights, counters zero; line stores read as zero until
// written (fill count, no clearing pass), so items are taken right after reset.
module conv3x3_image_filter #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [cif_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cif_pkg::CFG_DATA_W-1:0]    cfg_data,
    cif_pixel_if.sink                         pixels,
    cif_result_if.source                      results
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int PB = cif_pkg::PIXEL_BITS;
    localparam int RW = cif_pkg::ROW_W;
    // reset width, held to the widest row the line store takes
    localparam int W_RESET = (int'(cif_pkg::SIZE_RESET) < MAX_WIDTH)
                           ? int'(cif_pkg::SIZE_RESET) : MAX_WIDTH;

    // configuration
    logic [AW-1:0]                   w_last_reg;
    logic [RW-1:0]                   h_last_reg;
    logic [cif_pkg::CFG_DATA_W-1:0]  coef_top_reg;
    logic [cif_pkg::CFG_DATA_W-1:0]  coef_middle_reg;
    logic [cif_pkg::CFG_DATA_W-1:0]  coef_bottom_reg;
    int                              w_clamp;
    int                              h_clamp;

    // position of the next input item
    logic [AW-1:0]     col_reg;
    logic [AW-1:0]     col_next;
    logic [RW-1:0]     row_reg;
    logic [RW-1:0]     row_next;
    logic [RW-1:0]     rc;
    cif_pkg::cif_ctl_t ctl_in;
    logic              accept;

    // pipeline
    logic                            load1, load2, load3, load4, load5;
    logic                            s1_v_reg;
    cif_pkg::cif_ctl_t               s1_ctl_reg;
    logic [PB-1:0]                   s1_pix_reg;
    logic [AW-1:0]                   s1_col_reg;
    logic                            s1_drain;
    cif_pkg::cif_pair_t              ls_rd;
    cif_pkg::cif_pair_t              ls_wr;
    logic [PB-1:0]                   win_reg  [9];
    logic [PB-1:0]                   win_next [9];
    logic [cif_pkg::CFG_DATA_W-1:0]  coef_rows [3];
    logic signed [cif_pkg::PROD_W-1:0] prod_c [9];

    logic                              s2_v_reg;
    cif_pkg::cif_ctl_t                 s2_ctl_reg;
    logic signed [cif_pkg::PROD_W-1:0] s2_prod_reg [9];
    logic signed [cif_pkg::SUM_W-1:0]  sum_c;

    logic                              s3_v_reg;
    cif_pkg::cif_ctl_t                 s3_ctl_reg;
    logic signed [cif_pkg::SUM_W-1:0]  s3_sum_reg;
    logic [cif_pkg::MAG_W-1:0]         mag_c;

    logic                              s4_v_reg;
    cif_pkg::cif_ctl_t                 s4_ctl_reg;
    logic                              s4_neg_reg;
    logic [cif_pkg::DIVP_W-1:0]        s4_prod_reg;
    logic [cif_pkg::RESULT_W-1:0]      quot_c;

    logic                              res_v_reg;
    logic signed [cif_pkg::RESULT_W-1:0] res_filtered_reg;
    logic                              res_row_last_reg;
    logic                              res_frame_last_reg;

    // ---------------- configuration ----------------
    always_comb
    begin
        w_clamp = int'(cfg_data[cif_pkg::SIZE_W-1:0]);
        h_clamp = int'(cfg_data[cif_pkg::SIZE_W-1:0]);
        if (w_clamp < 3)
        begin
            w_clamp = 3;
        end
        if (w_clamp > MAX_WIDTH)
        begin
            w_clamp = MAX_WIDTH;
        end
        if (h_clamp < 3)
        begin
            h_clamp = 3;
        end
        if (h_clamp > cif_pkg::MAX_HEIGHT)
        begin
            h_clamp = cif_pkg::MAX_HEIGHT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_last_reg      <= AW'(W_RESET - 1);
            h_last_reg      <= RW'(int'(cif_pkg::SIZE_RESET) - 1);
            coef_top_reg    <= cif_pkg::COEF_ALL_NEG;
            coef_middle_reg <= cif_pkg::COEF_CENTER8;
            coef_bottom_reg <= cif_pkg::COEF_ALL_NEG;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                cif_pkg::REG_IMAGE_WIDTH:  w_last_reg      <= AW'(w_clamp - 1);
                cif_pkg::REG_IMAGE_HEIGHT: h_last_reg      <= RW'(h_clamp - 1);
                cif_pkg::REG_COEF_TOP:     coef_top_reg    <= cfg_data;
                cif_pkg::REG_COEF_MIDDLE:  coef_middle_reg <= cfg_data;
                cif_pkg::REG_COEF_BOTTOM:  coef_bottom_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- position and result decision ----------------
    assign load5  = !res_v_reg || results.ready;
    assign load4  = !s4_v_reg || load5;
    assign load3  = !s3_v_reg || load4;
    assign load2  = !s2_v_reg || load3;
    assign load1  = !s1_v_reg || load2;
    assign pixels.ready = load1;
    assign accept = pixels.valid && load1;

    always_comb
    begin
        // center lies one row up and one column left; at column zero it is the row end
        rc                 = (col_reg != '0) ? row_reg - 1'b1 : row_reg - 2'd2;
        ctl_in.have        = ((col_reg != '0) && (row_reg != '0))
                          || ((col_reg == '0) && (row_reg >= RW'(2)));
        ctl_in.have        = ctl_in.have && (rc <= h_last_reg);
        ctl_in.skip_left   = col_reg == AW'(1);
        ctl_in.skip_right  = col_reg == '0;
        ctl_in.skip_top    = rc == '0;
        ctl_in.skip_bottom = rc == h_last_reg;
        ctl_in.row_last    = col_reg == '0;
        ctl_in.frame_last  = ctl_in.row_last && ctl_in.skip_bottom;

        if (col_reg == w_last_reg)
        begin
            col_next = '0;
            row_next = row_reg + 1'b1;
        end
        else
        begin
            col_next = col_reg + 1'b1;
            row_next = row_reg;
        end
        if (ctl_in.have && ctl_in.frame_last)
        begin
            col_next = '0;
            row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_wr_en && ((cfg_index == cif_pkg::REG_IMAGE_WIDTH)
                            || (cfg_index == cif_pkg::REG_IMAGE_HEIGHT)))
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- stage 1: line store read, window shift ----------------
    assign s1_drain    = s1_v_reg && load2;
    assign ls_wr.upper = ls_rd.lower;
    assign ls_wr.lower = s1_pix_reg;

    cif_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .wr_en   (s1_drain),
        .wr_addr (s1_col_reg),
        .wr_data (ls_wr),
        .rd_data (ls_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (load1)
        begin
            s1_v_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctl_reg <= ctl_in;
            s1_pix_reg <= pixels.op ? '0 : pixels.pixel;
            s1_col_reg <= col_reg;
        end
    end

    assign coef_rows[0] = coef_top_reg;
    assign coef_rows[1] = coef_middle_reg;
    assign coef_rows[2] = coef_bottom_reg;

    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            win_next[k] = win_reg[k + 3];
        end
        win_next[6] = ls_rd.upper;
        win_next[7] = ls_rd.lower;
        win_next[8] = s1_pix_reg;

        for (int col = 0; col < 3; col++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod_c[col * 3 + j] =
                    $signed(coef_rows[j][col * cif_pkg::COEF_W +: cif_pkg::COEF_W])
                    * $signed({1'b0, win_next[col * 3 + j]});
                // drop neighbors outside the image
                if ((col == 0 && s1_ctl_reg.skip_left)
                 || (col == 2 && s1_ctl_reg.skip_right)
                 || (j == 0 && s1_ctl_reg.skip_top)
                 || (j == 2 && s1_ctl_reg.skip_bottom))
                begin
                    prod_c[col * 3 + j] = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 9; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else if (s1_drain)
        begin
            for (int k = 0; k < 9; k++)
            begin
                win_reg[k] <= win_next[k];
            end
        end
    end

    // ---------------- stage 2: products ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (load2)
        begin
            s2_v_reg <= s1_v_reg && s1_ctl_reg.have;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_drain)
        begin
            s2_ctl_reg <= s1_ctl_reg;
            for (int k = 0; k < 9; k++)
            begin
                s2_prod_reg[k] <= prod_c[k];
            end
        end
    end

    // ---------------- stage 3: sum ----------------
    always_comb
    begin
        sum_c = '0;
        for (int k = 0; k < 9; k++)
        begin
            sum_c = sum_c + cif_pkg::SUM_W'(s2_prod_reg[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
        end
        else if (load3)
        begin
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load3 && s2_v_reg)
        begin
            s3_ctl_reg <= s2_ctl_reg;
            s3_sum_reg <= sum_c;
        end
    end

    // ---------------- stage 4: magnitude times reciprocal of 9 ----------------
    assign mag_c = cif_pkg::MAG_W'(s3_sum_reg[cif_pkg::SUM_W-1] ? -s3_sum_reg : s3_sum_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_v_reg <= 1'b0;
        end
        else if (load4)
        begin
            s4_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load4 && s3_v_reg)
        begin
            s4_ctl_reg  <= s3_ctl_reg;
            s4_neg_reg  <= s3_sum_reg[cif_pkg::SUM_W-1];
            s4_prod_reg <= cif_pkg::DIVP_W'(mag_c) * cif_pkg::DIVP_W'(cif_pkg::DIV9_RECIP);
        end
    end

    // ---------------- stage 5: output register ----------------
    // quotient magnitude stays below 2**15; restore the sign, truncation is toward zero
    assign quot_c = cif_pkg::RESULT_W'(s4_prod_reg[cif_pkg::DIVP_W-1:cif_pkg::DIV9_SHIFT]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_v_reg <= 1'b0;
        end
        else if (load5)
        begin
            res_v_reg <= s4_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load5 && s4_v_reg)
        begin
            res_filtered_reg   <= s4_neg_reg ? -quot_c : quot_c;
            res_row_last_reg   <= s4_ctl_reg.row_last;
            res_frame_last_reg <= s4_ctl_reg.frame_last;
        end
    end

    assign results.valid      = res_v_reg;
    assign results.filtered   = res_filtered_reg;
    assign results.row_last   = res_row_last_reg;
    assign results.frame_last = res_frame_last_reg;

    // ---------------- assertions ----------------
    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= w_last_reg)
        else $error("input column beyond row width");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && ctl_in.have && ctl_in.frame_last |=> (col_reg == '0) && (row_reg == '0))
        else $error("frame did not restart after its last result");

    a_frame_is_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_v_reg && res_frame_last_reg |-> res_row_last_reg)
        else $error("frame end not on a row end");

    a_write_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_v_reg && (s1_col_reg == $past(col_reg)))
        else $error("line store write address lost");

endmodule
